// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property at every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that a condition never holds
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

// File: rtl/wms_pkg.sv
`timescale 1ns / 1ps

package wms_pkg;

  typedef enum logic [1:0] {
    REG_FILTER_MODE  = 2'd0,
    REG_LINE_WIDTH   = 2'd1,
    REG_FRAME_HEIGHT = 2'd2
  } cfg_reg_t;

  localparam logic [1:0] MODE_MEAN    = 2'd0;
  localparam logic [1:0] MODE_SHARPEN = 2'd1;
  localparam logic [1:0] MODE_MEDIAN  = 2'd2;

  localparam int CFG_DATA_W = 13;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;
  localparam int QCNT_W     = 3;

  // 17*centre - 8 neighbours == 18*centre - sum of all nine
  localparam logic [4:0]  SHARP_CTR_MUL = 5'd18;
  // x / 9 == (x * 3641) >> 15 for x below 8192
  localparam logic [11:0] DIV9_MUL   = 12'd3641;
  localparam int          DIV9_SHIFT = 15;

  typedef struct packed {
    logic [7:0] pix;
    logic       emit;
    logic       interior;
    logic       eof;
  } cmd_t;

  typedef struct packed {
    logic [7:0] top;
    logic [7:0] mid;
    cmd_t       cmd;
  } col_item_t;

endpackage

// File: rtl/wms_front.sv
`timescale 1ns / 1ps

module wms_front #(
  parameter int MAX_LINE_WIDTH   = 1024,
  parameter int MAX_FRAME_HEIGHT = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_addr,
  input  logic [wms_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,
  input  logic                            in_tuser,
  input  logic                            space_ok,
  input  logic                            lines_busy,
  output logic                            proc_valid,
  output logic [$clog2(MAX_LINE_WIDTH)-1:0] proc_idx,
  output wms_pkg::cmd_t                   proc_cmd,
  output logic [1:0]                      filter_mode
);
  localparam int CW = $clog2(MAX_LINE_WIDTH);
  localparam int WB = CW + 1;
  localparam int HB = $clog2(MAX_FRAME_HEIGHT) + 1;
  localparam int RB = HB + 1;
  localparam int OB = WB + HB;

  logic [1:0]  mode_r;
  logic [10:0] width_r;
  logic [12:0] height_r;
  logic        cfg_pend_r;
  logic [OB-1:0] total_r;
  logic [CW-1:0] col_r, col_nxt;
  logic [RB-1:0] row_r, row_nxt;
  logic [OB-1:0] oe_r, oe_nxt;

  logic [31:0] lw32, lh32, wc32, hc32;
  logic [WB-1:0] w_val;
  logic [HB-1:0] h_val;
  logic [OB-1:0] prod;
  logic fire, drain, proc, emit, interior, eof;
  logic [OB-1:0] oe_inc;

  assign cfg_ready = 1'b1;
  assign filter_mode = mode_r;

  always_comb begin
    lw32 = 32'(width_r);
    lh32 = 32'(height_r);
    if (lw32 < 32'd3) wc32 = 32'd3;
    else if (lw32 > 32'(MAX_LINE_WIDTH)) wc32 = 32'(MAX_LINE_WIDTH);
    else wc32 = lw32;
    if (lh32 < 32'd3) hc32 = 32'd3;
    else if (lh32 > 32'(MAX_FRAME_HEIGHT)) hc32 = 32'(MAX_FRAME_HEIGHT);
    else hc32 = lh32;
    w_val = wc32[WB-1:0];
    h_val = hc32[HB-1:0];
    prod  = OB'(w_val) * OB'(h_val);
  end

  assign in_tready = !cfg_pend_r && !lines_busy && space_ok;
  assign fire      = in_tvalid && in_tready;
  assign drain     = row_r >= RB'(h_val);
  assign proc      = fire && (!in_tuser || drain);
  assign emit      = (row_r >= RB'(2)) || (row_r == RB'(1) && col_r >= CW'(1));
  assign interior  = (col_r >= CW'(2)) && (WB'(col_r) <= w_val - WB'(1)) &&
                     (row_r >= RB'(2)) && (row_r <= RB'(h_val) - RB'(1));
  assign oe_inc    = oe_r + OB'(1);
  assign eof       = emit && (oe_inc >= total_r);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    oe_nxt  = oe_r;
    if (proc) begin
      if (emit) oe_nxt = oe_inc;
      if (eof) begin
        col_nxt = '0;
        row_nxt = '0;
        oe_nxt  = '0;
      end else if (WB'(col_r) + WB'(1) >= w_val) begin
        col_nxt = '0;
        row_nxt = row_r + RB'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  assign proc_valid        = proc;
  assign proc_idx          = col_r;
  assign proc_cmd.pix      = drain ? 8'd0 : in_tdata;
  assign proc_cmd.emit     = emit;
  assign proc_cmd.interior = interior;
  assign proc_cmd.eof      = eof;

  always_ff @(posedge clk) begin
    total_r <= prod;
    if (!rst_n) begin
      mode_r     <= wms_pkg::MODE_MEAN;
      width_r    <= 11'd640;
      height_r   <= 13'd480;
      cfg_pend_r <= 1'b0;
      col_r      <= '0;
      row_r      <= '0;
      oe_r       <= '0;
    end else begin
      cfg_pend_r <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_addr)
          wms_pkg::REG_FILTER_MODE:  mode_r   <= cfg_data[1:0];
          wms_pkg::REG_LINE_WIDTH:   width_r  <= cfg_data[10:0];
          wms_pkg::REG_FRAME_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end
      col_r <= col_nxt;
      row_r <= row_nxt;
      oe_r  <= oe_nxt;
    end
  end

endmodule

// File: rtl/wms_lines.sv
`timescale 1ns / 1ps

module wms_lines #(
  parameter int MAX_LINE_WIDTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              proc_valid,
  input  logic [$clog2(MAX_LINE_WIDTH)-1:0] proc_idx,
  input  wms_pkg::cmd_t                     proc_cmd,
  output logic                              busy,
  output logic                              item_valid,
  output wms_pkg::col_item_t                item
);
  localparam int CW = $clog2(MAX_LINE_WIDTH);
  localparam int KB = CW + 1;

  logic [7:0] upper_mem [MAX_LINE_WIDTH];
  logic [7:0] middle_mem [MAX_LINE_WIDTH];

  logic [KB-1:0] clr_r;
  logic          v1_r;
  logic [CW-1:0] idx1_r;
  wms_pkg::cmd_t cmd1_r;
  logic [7:0]    top_rd_r, mid_rd_r, fwd_val_r;
  logic          fwd_r;
  logic [CW-1:0] clr_idx;

  assign busy    = clr_r != KB'(MAX_LINE_WIDTH);
  assign clr_idx = clr_r[CW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      v1_r  <= 1'b0;
      fwd_r <= 1'b0;
    end else begin
      if (busy) clr_r <= clr_r + KB'(1);
      v1_r <= proc_valid;
      if (proc_valid) fwd_r <= v1_r && (idx1_r == proc_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (proc_valid) begin
      idx1_r    <= proc_idx;
      cmd1_r    <= proc_cmd;
      top_rd_r  <= upper_mem[proc_idx];
      mid_rd_r  <= middle_mem[proc_idx];
      fwd_val_r <= mid_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) middle_mem[clr_idx] <= 8'd0;
    else if (proc_valid) middle_mem[proc_idx] <= proc_cmd.pix;
  end

  always_ff @(posedge clk) begin
    if (busy) upper_mem[clr_idx] <= 8'd0;
    else if (v1_r) upper_mem[idx1_r] <= mid_rd_r;
  end

  assign item_valid = v1_r;
  assign item.top   = fwd_r ? fwd_val_r : top_rd_r;
  assign item.mid   = mid_rd_r;
  assign item.cmd   = cmd1_r;

endmodule

// File: rtl/wms_queue.sv
`timescale 1ns / 1ps

module wms_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  wms_pkg::col_item_t           push_item,
  input  logic                         pop,
  output logic                         empty,
  output wms_pkg::col_item_t           head,
  output logic [wms_pkg::QCNT_W-1:0]   count
);
  wms_pkg::col_item_t mem_r [wms_pkg::QDEPTH];
  logic [wms_pkg::QPTR_W-1:0] wr_r, rd_r;
  logic [wms_pkg::QCNT_W-1:0] cnt_r;
  logic do_pop;

  assign empty  = cnt_r == '0;
  assign count  = cnt_r;
  assign head   = mem_r[rd_r];
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + wms_pkg::QPTR_W'(1);
      if (do_pop) rd_r <= rd_r + wms_pkg::QPTR_W'(1);
      cnt_r <= cnt_r + wms_pkg::QCNT_W'(push) - wms_pkg::QCNT_W'(do_pop);
    end
  end

endmodule

// File: rtl/wms_back.sv
`timescale 1ns / 1ps

module wms_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         filter_mode,
  input  logic               q_empty,
  input  wms_pkg::col_item_t q_head,
  output logic               q_pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,
  output logic               out_tlast
);
  logic [7:0] win_r [9];
  logic       v0_r, v1_r, v2_r;
  wms_pkg::cmd_t f0_r, f1_r, f2_r;
  logic advance;

  logic [11:0] sum_c, sum_r;
  logic [7:0]  ctr1_r, ctr2_r;
  logic [7:0]  lo_c [3], md_c [3], hi_c [3];
  logic [7:0]  lo_r [3], md_r [3], hi_r [3];

  logic [7:0]  med_c, med_r;
  logic [23:0] mean_prod_r;
  logic [12:0] sharp_n;
  logic        sharp_neg_c, sharp_neg_r;
  logic [24:0] sharp_prod_r;
  logic [13:0] sharp_s;

  logic [7:0] out_val_c, out_data_r;
  logic       out_valid_r, out_last_r;
  logic [8:0] mean_q;
  logic [9:0] sharp_q;

  function automatic logic [7:0] min2(input logic [7:0] a, input logic [7:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [7:0] max2(input logic [7:0] a, input logic [7:0] b);
    return (a < b) ? b : a;
  endfunction

  function automatic logic [7:0] med3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  assign advance = !out_valid_r || out_tready;
  assign q_pop   = advance && !q_empty;

  always_comb begin
    sum_c = '0;
    for (int i = 0; i < 9; i++) sum_c = sum_c + 12'(win_r[i]);
    for (int r = 0; r < 3; r++) begin
      lo_c[r] = min2(min2(win_r[3*r], win_r[3*r+1]), win_r[3*r+2]);
      hi_c[r] = max2(max2(win_r[3*r], win_r[3*r+1]), win_r[3*r+2]);
      md_c[r] = med3(win_r[3*r], win_r[3*r+1], win_r[3*r+2]);
    end
  end

  always_comb begin
    med_c = med3(max2(max2(lo_r[0], lo_r[1]), lo_r[2]),
                 med3(md_r[0], md_r[1], md_r[2]),
                 min2(min2(hi_r[0], hi_r[1]), hi_r[2]));
    sharp_s     = 14'(ctr1_r) * 14'(wms_pkg::SHARP_CTR_MUL) - 14'(sum_r);
    sharp_neg_c = sharp_s[13];
    sharp_n     = sharp_s[12:0];
  end

  always_comb begin
    mean_q  = mean_prod_r[23:wms_pkg::DIV9_SHIFT];
    sharp_q = sharp_prod_r[24:wms_pkg::DIV9_SHIFT];
    out_val_c = ctr2_r;
    if (f2_r.interior) begin
      unique case (filter_mode)
        wms_pkg::MODE_MEAN:    out_val_c = mean_q[7:0];
        wms_pkg::MODE_SHARPEN: begin
          if (sharp_neg_r) out_val_c = 8'd0;
          else if (sharp_q > 10'd255) out_val_c = 8'd255;
          else out_val_c = sharp_q[7:0];
        end
        wms_pkg::MODE_MEDIAN:  out_val_c = med_r;
        default:               out_val_c = ctr2_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) win_r[i] <= 8'd0;
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      v0_r <= q_pop;
      if (q_pop) begin
        win_r[0] <= win_r[1];
        win_r[1] <= win_r[2];
        win_r[3] <= win_r[4];
        win_r[4] <= win_r[5];
        win_r[6] <= win_r[7];
        win_r[7] <= win_r[8];
        win_r[2] <= q_head.top;
        win_r[5] <= q_head.mid;
        win_r[8] <= q_head.cmd.pix;
      end
      v1_r        <= v0_r;
      v2_r        <= v1_r;
      out_valid_r <= v2_r && f2_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (q_pop) f0_r <= q_head.cmd;
      f1_r    <= f0_r;
      sum_r   <= sum_c;
      ctr1_r  <= win_r[4];
      lo_r    <= lo_c;
      md_r    <= md_c;
      hi_r    <= hi_c;
      f2_r         <= f1_r;
      ctr2_r       <= ctr1_r;
      med_r        <= med_c;
      mean_prod_r  <= 24'(sum_r) * 24'(wms_pkg::DIV9_MUL);
      sharp_neg_r  <= sharp_neg_c;
      sharp_prod_r <= 25'(sharp_n) * 25'(wms_pkg::DIV9_MUL);
      out_data_r   <= out_val_c;
      out_last_r   <= f2_r.eof;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// File: rtl/window3x3_mean_sharpen_median.sv
`timescale 1ns / 1ps
// A result beat follows its pixel beat through the line stores, the column queue and the back end's registers.
// Throughput: one pixel beat per cycle while in_tready is high; the line stores take one beat a cycle.
// Reset: synchronous, active low; a clearing pass then zeroes the line stores,
// during which in_tready stays low.
// in_tready also drops for one cycle after each register write.

`include "assert_macros.svh"

module window3x3_mean_sharpen_median #(
  parameter int MAX_LINE_WIDTH   = 1024,
  parameter int MAX_FRAME_HEIGHT = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_addr,
  input  logic [wms_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,  // [7:0] pixel_in
  input  logic                            in_tuser,  // [0] is_flush
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata, // [7:0] pixel_out
  output logic                            out_tlast
);
  localparam int CW = $clog2(MAX_LINE_WIDTH);

  logic                         proc_valid;
  logic [CW-1:0]                proc_idx;
  wms_pkg::cmd_t                proc_cmd;
  logic [1:0]                   filter_mode;
  logic                         lines_busy;
  logic                         item_valid;
  wms_pkg::col_item_t           item;
  logic                         q_empty, q_pop;
  wms_pkg::col_item_t           q_head;
  logic [wms_pkg::QCNT_W-1:0]   q_count;
  logic                         space_ok;

  assign space_ok = (q_count + wms_pkg::QCNT_W'(item_valid)) <
                    wms_pkg::QCNT_W'(wms_pkg::QDEPTH);

  wms_front #(
    .MAX_LINE_WIDTH  (MAX_LINE_WIDTH),
    .MAX_FRAME_HEIGHT(MAX_FRAME_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .space_ok   (space_ok),
    .lines_busy (lines_busy),
    .proc_valid (proc_valid),
    .proc_idx   (proc_idx),
    .proc_cmd   (proc_cmd),
    .filter_mode(filter_mode)
  );

  wms_lines #(
    .MAX_LINE_WIDTH(MAX_LINE_WIDTH)
  ) u_lines (
    .clk       (clk),
    .rst_n     (rst_n),
    .proc_valid(proc_valid),
    .proc_idx  (proc_idx),
    .proc_cmd  (proc_cmd),
    .busy      (lines_busy),
    .item_valid(item_valid),
    .item      (item)
  );

  wms_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (item_valid),
    .push_item(item),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head),
    .count    (q_count)
  );

  wms_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .filter_mode(filter_mode),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  `ASSERT_NEVER(a_queue_overflow, item_valid && !q_pop && (q_count == wms_pkg::QCNT_W'(wms_pkg::QDEPTH)), "queue overflow")
  `ASSERT_CLK(a_no_accept_while_clearing, in_tready |-> !lines_busy, "input taken during clear")
  `ASSERT_CLK(a_cfg_blocks_input, cfg_valid && cfg_ready |=> !in_tready, "input taken after register write")

endmodule
